// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the correlation search RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define BLC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("blc assertion failed");
// cons must hold in the cycle after ante
`define BLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blc assertion failed");
`else
`define BLC_ASSERT(lbl, clk, rst_n, prop)
`define BLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/blc_pkg.sv =====
// ----------------------------------------------------------------------------
// blc_pkg
// Sizes, widths and shared types of the best-lag correlation search.
// ----------------------------------------------------------------------------
package blc_pkg;

    localparam int SHORT_DEPTH = 256;
    localparam int LONG_DEPTH  = 512;
    localparam int SAMPLE_BITS = 16;
    localparam int NUM_CELLS   = 8;

    localparam int CFG_W   = 10;
    localparam int CFG_RST = 512;
    localparam int Q_BITS  = 15;
    localparam int QW      = Q_BITS + 1;
    localparam logic [QW-1:0] ONE_Q = QW'(1) << Q_BITS;

    localparam int SA_W   = $clog2(SHORT_DEPTH);
    localparam int LA_W   = $clog2(LONG_DEPTH);
    localparam int SC_W   = $clog2(SHORT_DEPTH + 1);
    localparam int LC_W   = $clog2(LONG_DEPTH + 1);
    localparam int CI_W   = $clog2(NUM_CELLS);
    localparam int J_W    = $clog2(NUM_CELLS + SHORT_DEPTH + 1);
    localparam int BASE_W = $clog2(LONG_DEPTH + NUM_CELLS + 1);
    localparam int BIT_W  = $clog2(QW);

    // sum widths: first and second order
    localparam int S1_W   = SAMPLE_BITS + SA_W;
    localparam int S2_W   = 2 * SAMPLE_BITS + SA_W;
    // n*S2 and S1*S1 terms
    localparam int D_W    = 2 * SAMPLE_BITS + 2 * SA_W;
    localparam int LIMB_W = D_W / 2;
    localparam int AW     = 2 * D_W + 1;
    localparam int PRD_W  = 2 * D_W;
    localparam int PW     = PRD_W + QW;
    localparam int SW     = PRD_W + 2 * QW;

    typedef struct packed {
        logic dv;
        logic comp;
    } t_cell_ctl;

    typedef struct packed {
        logic [S1_W-1:0] sy;
        logic [S2_W-1:0] syy;
        logic [S2_W-1:0] sxy;
    } t_sums;

    typedef struct packed {
        logic          busy;
        logic          done;
        logic [QW-1:0] q;
    } t_corr_stat;

endpackage

// ===== hdl/blc_cell.sv =====
// ----------------------------------------------------------------------------
// blc_cell
// One lag cell: holds a long sample, passes it down the chain, and
// accumulates Sy, Syy and Sxy against the broadcast short sample.
// ----------------------------------------------------------------------------
module blc_cell (
    input  logic                              i_clk,
    input  blc_pkg::t_cell_ctl                i_ctl,
    input  logic [blc_pkg::SAMPLE_BITS-1:0]   i_x,
    input  logic [blc_pkg::SAMPLE_BITS-1:0]   i_y_in,
    output logic [blc_pkg::SAMPLE_BITS-1:0]   o_y,
    output blc_pkg::t_sums                    o_sums
);
    import blc_pkg::*;

    logic [SAMPLE_BITS-1:0]   r_y;
    t_sums                    r_sums;
    logic [2*SAMPLE_BITS-1:0] s_xy;
    logic [2*SAMPLE_BITS-1:0] s_yy;

    assign s_xy = i_x * r_y;
    assign s_yy = r_y * r_y;

    // fill data clears the sums, compute data accumulates
    always_ff @(posedge i_clk) begin
        if (i_ctl.dv) begin
            r_y <= i_y_in;
            if (i_ctl.comp) begin
                r_sums.sy  <= r_sums.sy + S1_W'(r_y);
                r_sums.syy <= r_sums.syy + S2_W'(s_yy);
                r_sums.sxy <= r_sums.sxy + S2_W'(s_xy);
            end else begin
                r_sums <= '0;
            end
        end
    end

    assign o_y    = r_y;
    assign o_sums = r_sums;

endmodule

// ===== hdl/blc_corr.sv =====
// ----------------------------------------------------------------------------
// blc_corr
// Correlation of one lag in Q1.15 from exact sums: wide products over
// 24-bit limbs on one multiplier, then a bit-per-step search for the
// largest q with q^2*A*B <= 2^30*nom^2.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module blc_corr (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [blc_pkg::SC_W-1:0]    i_n,
    input  logic [blc_pkg::S1_W-1:0]    i_sx,
    input  logic [blc_pkg::S2_W-1:0]    i_sxx,
    input  blc_pkg::t_sums              i_sums,
    output blc_pkg::t_corr_stat         o_stat
);
    import blc_pkg::*;

    localparam logic [1:0] CS_IDLE  = 2'd0;
    localparam logic [1:0] CS_MUL   = 2'd1;
    localparam logic [1:0] CS_SRCH0 = 2'd2;
    localparam logic [1:0] CS_SRCH1 = 2'd3;

    localparam logic [2:0] OP_NSXX = 3'd0;
    localparam logic [2:0] OP_SXSX = 3'd1;
    localparam logic [2:0] OP_NSYY = 3'd2;
    localparam logic [2:0] OP_SYSY = 3'd3;
    localparam logic [2:0] OP_NSXY = 3'd4;
    localparam logic [2:0] OP_SXSY = 3'd5;
    localparam logic [2:0] OP_AB   = 3'd6;
    localparam logic [2:0] OP_NN   = 3'd7;

    localparam logic [2:0] T_LAST = 3'd4;

    logic [1:0]       r_state;
    logic [2:0]       r_op;
    logic [2:0]       r_t;
    logic [BIT_W-1:0] r_bit;
    logic             r_done;

    logic [AW-1:0]    r_acc;
    logic [D_W-1:0]   r_pp;
    logic [1:0]       r_sh;
    logic [D_W-1:0]   r_a;
    logic [D_W-1:0]   r_b;
    logic [D_W-1:0]   r_nom;
    logic [PRD_W-1:0] r_ab;
    logic [SW-1:0]    r_l;
    logic [SW-1:0]    r_s;
    logic [PW-1:0]    r_p;
    logic [SW-1:0]    r_cand;
    logic [QW-1:0]    r_q;

    logic [D_W-1:0]    s_opa;
    logic [D_W-1:0]    s_opb;
    logic [LIMB_W-1:0] s_la;
    logic [LIMB_W-1:0] s_lb;
    logic [D_W-1:0]    s_pp;
    logic [AW-1:0]     s_shifted;
    logic [AW-1:0]     s_acc_n;
    logic              s_sub;
    logic              s_nom_pos;
    logic [SW-1:0]     s_cand;

    always_comb begin
        unique case (r_op)
            OP_NSXX: begin s_opa = D_W'(i_n);        s_opb = D_W'(i_sxx);        end
            OP_SXSX: begin s_opa = D_W'(i_sx);       s_opb = D_W'(i_sx);         end
            OP_NSYY: begin s_opa = D_W'(i_n);        s_opb = D_W'(i_sums.syy);   end
            OP_SYSY: begin s_opa = D_W'(i_sums.sy);  s_opb = D_W'(i_sums.sy);    end
            OP_NSXY: begin s_opa = D_W'(i_n);        s_opb = D_W'(i_sums.sxy);   end
            OP_SXSY: begin s_opa = D_W'(i_sx);       s_opb = D_W'(i_sums.sy);    end
            OP_AB:   begin s_opa = r_a;              s_opb = r_b;                end
            OP_NN:   begin s_opa = r_nom;            s_opb = r_nom;              end
            default: begin s_opa = '0;               s_opb = '0;                 end
        endcase
    end

    assign s_la = r_t[1] ? s_opa[D_W-1:LIMB_W] : s_opa[LIMB_W-1:0];
    assign s_lb = r_t[0] ? s_opb[D_W-1:LIMB_W] : s_opb[LIMB_W-1:0];
    assign s_pp = s_la * s_lb;

    // odd ops subtract the square term from the n*sum term
    assign s_sub = r_op[0] && (r_op != OP_NN);

    always_comb begin
        unique case (r_sh)
            2'd0:    s_shifted = AW'(r_pp);
            2'd1:    s_shifted = AW'(r_pp) << LIMB_W;
            2'd2:    s_shifted = AW'(r_pp) << (2 * LIMB_W);
            default: s_shifted = '0;
        endcase
    end

    assign s_acc_n   = s_sub ? (r_acc - s_shifted) : (r_acc + s_shifted);
    assign s_nom_pos = !s_acc_n[AW-1] && (s_acc_n != '0);

    // candidate (q + 2^b)^2 * AB, with r_p = q * AB
    assign s_cand = r_s + (SW'(r_p) << (r_bit + 1)) + (SW'(r_ab) << (2 * r_bit));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
            r_op    <= OP_NSXX;
            r_t     <= '0;
            r_bit   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                CS_IDLE: begin
                    if (i_start) begin
                        r_op    <= OP_NSXX;
                        r_t     <= '0;
                        r_state <= CS_MUL;
                    end
                end
                CS_MUL: begin
                    if (r_t != T_LAST) begin
                        r_t <= r_t + 3'd1;
                    end else begin
                        r_t <= '0;
                        if (r_op == OP_SXSY) begin
                            if (r_a == '0 || r_b == '0 || !s_nom_pos) begin
                                r_done  <= 1'b1;
                                r_state <= CS_IDLE;
                            end else begin
                                r_op <= OP_AB;
                            end
                        end else if (r_op == OP_NN) begin
                            r_bit   <= BIT_W'(Q_BITS);
                            r_state <= CS_SRCH0;
                        end else begin
                            r_op <= r_op + 3'd1;
                        end
                    end
                end
                CS_SRCH0: r_state <= CS_SRCH1;
                CS_SRCH1: begin
                    if (r_bit == '0) begin
                        r_done  <= 1'b1;
                        r_state <= CS_IDLE;
                    end else begin
                        r_bit   <= r_bit - BIT_W'(1);
                        r_state <= CS_SRCH0;
                    end
                end
                default: r_state <= CS_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            CS_MUL: begin
                if (!r_t[2]) begin
                    r_pp <= s_pp;
                    r_sh <= {1'b0, r_t[1]} + {1'b0, r_t[0]};
                end
                if (r_t == '0) begin
                    if (!s_sub) begin
                        r_acc <= '0;
                    end
                end else begin
                    r_acc <= s_acc_n;
                end
                if (r_t == T_LAST) begin
                    unique case (r_op)
                        OP_SXSX: r_a   <= s_acc_n[D_W-1:0];
                        OP_SYSY: r_b   <= s_acc_n[D_W-1:0];
                        OP_SXSY: begin
                            r_nom <= s_acc_n[D_W-1:0];
                            if (r_a == '0 || r_b == '0) begin
                                r_q <= ONE_Q;
                            end else if (!s_nom_pos) begin
                                r_q <= '0;
                            end
                        end
                        OP_AB:   r_ab  <= s_acc_n[PRD_W-1:0];
                        OP_NN: begin
                            r_l <= SW'(s_acc_n[PRD_W-1:0]) << (2 * Q_BITS);
                            r_s <= '0;
                            r_p <= '0;
                            r_q <= '0;
                        end
                        default: ;
                    endcase
                end
            end
            CS_SRCH0: r_cand <= s_cand;
            CS_SRCH1: begin
                if (r_cand <= r_l) begin
                    r_s        <= r_cand;
                    r_p        <= r_p + (PW'(r_ab) << r_bit);
                    r_q[r_bit] <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_stat.busy = (r_state != CS_IDLE);
    assign o_stat.done = r_done;
    assign o_stat.q    = r_q;

    `BLC_ASSERT(a_start_idle, i_clk, i_rst_n, !i_start || (r_state == CS_IDLE))
    `BLC_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start, r_state == CS_MUL)
    `BLC_ASSERT(a_q_range, i_clk, i_rst_n, !r_done || (r_q <= ONE_Q))

endmodule

// ===== hdl/best_lag_correlation_search_unit.sv =====
// ----------------------------------------------------------------------------
// best_lag_correlation_search_unit
// Loads a short and a long series, then finds the lag of highest Pearson
// correlation with a chain of lag cells and a shared correlation unit.
// ----------------------------------------------------------------------------
// Requests enter on start while busy is low: mode 0 appends the sample to
// the short series, mode 1 to the long series. A long request with last
// set starts the lag search. Bad lengths (empty series, long not longer
// than short) give status 1 on the cycle after the request, with busy
// staying low; a max_shift of 0 gives status 0 the same way. Otherwise
// the block goes busy. Lags run in groups of eight: the cell chain is
// filled with eight long samples, then the short series streams past.
// Each lag of the group then goes through the correlation unit: eight
// wide products in turn (six when a variance is zero or the numerator is
// not positive), then the bit search.
// The result shows on o_strobe for one cycle; the receiver cannot stall it.
// Both series counts clear with every result. max_shift is written through
// i_cfg_we / i_cfg_wdata, by the user only while idle; the block does not
// enforce this. It resets to 512.
// Reset is synchronous, active low; the sample stores are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module best_lag_correlation_search_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   i_cfg_we,
    input  logic [blc_pkg::CFG_W-1:0]              i_cfg_wdata,
    input  logic                                   i_mode,
    input  logic signed [blc_pkg::SAMPLE_BITS-1:0] i_sample,
    input  logic                                   i_last,
    output logic                                   o_strobe,
    output logic                                   o_status,
    output logic [blc_pkg::LA_W-1:0]               o_best_lag,
    output logic [blc_pkg::QW-1:0]                 o_best_corr
);
    import blc_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SWEEP = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_POST  = 3'd3;
    localparam logic [2:0] ST_WAIT  = 3'd4;

    localparam int CMP_W = BASE_W + CFG_W + LC_W;
    localparam int AD_W  = BASE_W + J_W;

    logic [2:0]        r_state;
    logic [CFG_W-1:0]  r_cfg;
    logic [SC_W-1:0]   r_sc;
    logic [LC_W-1:0]   r_lc;
    logic [CFG_W-1:0]  r_nlag;
    logic [BASE_W-1:0] r_base;
    logic [J_W-1:0]    r_j;
    logic [CI_W-1:0]   r_cidx;
    logic [QW-1:0]     r_best;
    logic [LA_W-1:0]   r_best_lag;
    t_cell_ctl         r_ctl;
    logic              r_o_strobe;
    logic              r_o_status;
    logic [LA_W-1:0]   r_o_best_lag;
    logic [QW-1:0]     r_o_best_corr;

    logic [SAMPLE_BITS-1:0] r_short_mem [SHORT_DEPTH];
    logic [SAMPLE_BITS-1:0] r_long_mem  [LONG_DEPTH];
    logic [SAMPLE_BITS-1:0] r_x_rd;
    logic [SAMPLE_BITS-1:0] r_y_rd;
    logic [S1_W-1:0]        r_sx;
    logic [S2_W-1:0]        r_sxx;

    logic                     s_accept;
    logic [SAMPLE_BITS-1:0]   s_val;
    logic                     s_sc_room;
    logic                     s_lc_room;
    logic                     s_short_we;
    logic                     s_long_we;
    logic [LC_W-1:0]          s_lc_new;
    logic                     s_bad;
    logic [LC_W-1:0]          s_diff;
    logic [CFG_W-1:0]         s_nlag;
    logic [AD_W-1:0]          s_laddr;
    logic [J_W-1:0]           s_saddr;
    logic [J_W-1:0]           s_j_end;
    logic [BASE_W-1:0]        s_lag;
    logic                     s_lag_ok;
    logic                     s_last_cell;
    logic                     s_more;
    logic                     s_win;
    logic [QW-1:0]            s_best_n;
    logic [LA_W-1:0]          s_best_lag_n;
    logic                     s_adv;
    logic                     s_corr_start;
    logic [2*SAMPLE_BITS-1:0] s_xx;
    t_corr_stat               s_corr;
    t_sums                    s_sel;

    logic [SAMPLE_BITS-1:0] s_cell_y    [NUM_CELLS];
    t_sums                  s_cell_sums [NUM_CELLS];

    assign s_accept   = start && !busy;
    // offset binary: flip the sign bit
    assign s_val      = {~i_sample[SAMPLE_BITS-1], i_sample[SAMPLE_BITS-2:0]};
    assign s_sc_room  = (r_sc < SC_W'(SHORT_DEPTH));
    assign s_lc_room  = (r_lc < LC_W'(LONG_DEPTH));
    assign s_short_we = s_accept && !i_mode && s_sc_room;
    assign s_long_we  = s_accept && i_mode && s_lc_room;
    assign s_lc_new   = r_lc + LC_W'(s_lc_room);
    assign s_bad      = (r_sc == '0) || (s_lc_new == '0)
                     || (CMP_W'(s_lc_new) <= CMP_W'(r_sc));
    assign s_diff     = s_lc_new - LC_W'(r_sc);
    assign s_nlag     = (CMP_W'(r_cfg) < CMP_W'(s_diff)) ? r_cfg : CFG_W'(s_diff);

    assign s_laddr = AD_W'(r_base) + AD_W'(r_j);
    assign s_saddr = r_j - J_W'(NUM_CELLS);
    assign s_j_end = J_W'(NUM_CELLS) + J_W'(r_sc) - J_W'(1);

    assign s_lag       = r_base + BASE_W'(r_cidx);
    assign s_lag_ok    = (CMP_W'(s_lag) < CMP_W'(r_nlag));
    assign s_last_cell = (r_cidx == CI_W'(NUM_CELLS - 1));
    assign s_more      = (CMP_W'(r_base) + CMP_W'(NUM_CELLS) < CMP_W'(r_nlag));

    assign s_win        = (r_state == ST_WAIT) && s_corr.done && (s_corr.q > r_best);
    assign s_best_n     = s_win ? s_corr.q : r_best;
    assign s_best_lag_n = s_win ? s_lag[LA_W-1:0] : r_best_lag;
    assign s_adv        = ((r_state == ST_POST) && !s_lag_ok)
                       || ((r_state == ST_WAIT) && s_corr.done);
    assign s_corr_start = (r_state == ST_POST) && s_lag_ok;

    always_ff @(posedge i_clk) begin
        if (s_short_we) begin
            r_short_mem[r_sc[SA_W-1:0]] <= s_val;
        end
        r_x_rd <= r_short_mem[s_saddr[SA_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (s_long_we) begin
            r_long_mem[r_lc[LA_W-1:0]] <= s_val;
        end
        r_y_rd <= r_long_mem[s_laddr[LA_W-1:0]];
    end

    assign s_xx = r_x_rd * r_x_rd;

    // lag-independent sums of the short series
    always_ff @(posedge i_clk) begin
        if (r_ctl.dv) begin
            if (r_ctl.comp) begin
                r_sx  <= r_sx + S1_W'(r_x_rd);
                r_sxx <= r_sxx + S2_W'(s_xx);
            end else begin
                r_sx  <= '0;
                r_sxx <= '0;
            end
        end
    end

    // cell c works on lag base + c; long samples move toward cell 0
    for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
        logic [SAMPLE_BITS-1:0] s_y_in;
        if (c == NUM_CELLS - 1) begin : g_head
            assign s_y_in = r_y_rd;
        end else begin : g_body
            assign s_y_in = s_cell_y[c+1];
        end
        blc_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (r_ctl),
            .i_x    (r_x_rd),
            .i_y_in (s_y_in),
            .o_y    (s_cell_y[c]),
            .o_sums (s_cell_sums[c])
        );
    end

    assign s_sel = s_cell_sums[r_cidx];

    blc_corr u_corr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_corr_start),
        .i_n     (r_sc),
        .i_sx    (r_sx),
        .i_sxx   (r_sxx),
        .i_sums  (s_sel),
        .o_stat  (s_corr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_cfg         <= CFG_W'(CFG_RST);
            r_sc          <= '0;
            r_lc          <= '0;
            r_nlag        <= '0;
            r_base        <= '0;
            r_j           <= '0;
            r_cidx        <= '0;
            r_best        <= '0;
            r_best_lag    <= '0;
            r_ctl         <= '0;
            r_o_strobe    <= 1'b0;
            r_o_status    <= 1'b0;
            r_o_best_lag  <= '0;
            r_o_best_corr <= '0;
        end else begin
            r_o_strobe <= 1'b0;
            r_ctl      <= '0;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_accept) begin
                        if (!i_mode) begin
                            if (s_sc_room) begin
                                r_sc <= r_sc + SC_W'(1);
                            end
                        end else if (!i_last) begin
                            r_lc <= s_lc_new;
                        end else if (s_bad || s_nlag == '0) begin
                            r_o_strobe    <= 1'b1;
                            r_o_status    <= s_bad;
                            r_o_best_lag  <= '0;
                            r_o_best_corr <= '0;
                            r_sc          <= '0;
                            r_lc          <= '0;
                        end else begin
                            r_lc       <= s_lc_new;
                            r_nlag     <= s_nlag;
                            r_base     <= '0;
                            r_j        <= '0;
                            r_best     <= '0;
                            r_best_lag <= '0;
                            r_state    <= ST_SWEEP;
                        end
                    end
                end
                ST_SWEEP: begin
                    r_ctl.dv   <= 1'b1;
                    r_ctl.comp <= (r_j >= J_W'(NUM_CELLS));
                    r_j        <= r_j + J_W'(1);
                    if (r_j == s_j_end) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_cidx  <= '0;
                    r_state <= ST_POST;
                end
                ST_POST: begin
                    if (s_lag_ok) begin
                        r_state <= ST_WAIT;
                    end
                end
                ST_WAIT: ;
                default: r_state <= ST_IDLE;
            endcase

            if (s_adv) begin
                r_best     <= s_best_n;
                r_best_lag <= s_best_lag_n;
                if (!s_last_cell) begin
                    r_cidx  <= r_cidx + CI_W'(1);
                    r_state <= ST_POST;
                end else if (s_more) begin
                    r_base  <= r_base + BASE_W'(NUM_CELLS);
                    r_j     <= '0;
                    r_state <= ST_SWEEP;
                end else begin
                    r_o_strobe    <= 1'b1;
                    r_o_status    <= 1'b0;
                    r_o_best_lag  <= s_best_lag_n;
                    r_o_best_corr <= s_best_n;
                    r_sc          <= '0;
                    r_lc          <= '0;
                    r_state       <= ST_IDLE;
                end
            end
        end
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_strobe    = r_o_strobe;
    assign o_status    = r_o_status;
    assign o_best_lag  = r_o_best_lag;
    assign o_best_corr = r_o_best_corr;

    `BLC_ASSERT(a_idle_corr_free, i_clk, i_rst_n, (r_state != ST_IDLE) || !s_corr.busy)
    `BLC_ASSERT(a_counts_clear, i_clk, i_rst_n, !r_o_strobe || (r_sc == '0 && r_lc == '0))
    `BLC_ASSERT_NEXT(a_done_leaves, i_clk, i_rst_n, s_corr.done, r_state != ST_WAIT)
    `BLC_ASSERT(a_best_range, i_clk, i_rst_n, r_best <= ONE_Q)

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the best-lag correlation search unit. A scoreboard
// class tracks both series and computes the expected search result for every
// long request carrying last. Directed cases come first, then random series.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import blc_pkg::*;

    localparam int ONE_Q15 = 32768;

    typedef struct {
        bit       status;
        bit [8:0] lag;
        bit [15:0] corr;
    } t_search_result;

    class lag_scoreboard;
        int unsigned    max_shift = CFG_RST;
        bit [15:0]      short_ser[SHORT_DEPTH];
        bit [15:0]      long_ser[LONG_DEPTH];
        int unsigned    short_cnt = 0;
        int unsigned    long_cnt  = 0;
        t_search_result expected[$];
        int             errors = 0;

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function int pending();
            return expected.size();
        endfunction

        // Pearson correlation at one lag, Q1.15 truncated, 0 if not positive, 1.0 if a series is constant
        function int unsigned corr_at(int unsigned lag);
            longint unsigned sx, sy, sxx, syy, sxy, x, y;
            bit [159:0] a, b, p, q, nom, lhs, ab, t;
            int unsigned lo, hi, mid;
            sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
            for (int k = 0; k < short_cnt; k++) begin
                x = short_ser[k];
                y = long_ser[lag + k];
                sx += x; sy += y;
                sxx += x * x; syy += y * y; sxy += x * y;
            end
            a = 160'(short_cnt) * 160'(sxx) - 160'(sx) * 160'(sx);
            b = 160'(short_cnt) * 160'(syy) - 160'(sy) * 160'(sy);
            if (a == 0 || b == 0) return ONE_Q15;
            p = 160'(short_cnt) * 160'(sxy);
            q = 160'(sx) * 160'(sy);
            if (p <= q) return 0;
            nom = p - q;
            lhs = (nom * nom) << 30;
            ab  = a * b;
            lo = 0;
            hi = ONE_Q15;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                t = ab * 160'(mid * mid);
                if (t <= lhs) lo = mid;
                else hi = mid - 1;
            end
            return lo;
        endfunction

        function void note_request(bit mode, bit [15:0] sample, bit last);
            t_search_result r;
            int unsigned c;
            bit [15:0] v;
            v = sample ^ 16'h8000;
            if (!mode) begin
                if (short_cnt < SHORT_DEPTH) short_ser[short_cnt++] = v;
                return;
            end
            if (long_cnt < LONG_DEPTH) long_ser[long_cnt++] = v;
            if (!last) return;
            r.status = 0; r.lag = 0; r.corr = 0;
            if (short_cnt == 0 || long_cnt <= short_cnt) begin
                r.status = 1;
            end else begin
                for (int unsigned lag = 0;
                     lag < max_shift && lag + short_cnt < long_cnt; lag++) begin
                    c = corr_at(lag);
                    if (c > r.corr) begin
                        r.corr = c;
                        r.lag  = lag;
                    end
                end
            end
            short_cnt = 0;
            long_cnt  = 0;
            expected.push_back(r);
        endfunction

        task check_result(bit status, bit [8:0] lag, bit [15:0] corr);
            t_search_result e;
            if (expected.size() == 0) begin
                report($sformatf("unexpected result status=%0d lag=%0d corr=%0d",
                                 status, lag, corr));
                return;
            end
            e = expected.pop_front();
            if (status !== e.status)
                report($sformatf("status got %0d want %0d", status, e.status));
            if (lag !== e.lag)
                report($sformatf("best_lag got %0d want %0d", lag, e.lag));
            if (corr !== e.corr)
                report($sformatf("best_corr got %0d want %0d", corr, e.corr));
        endtask
    endclass

    logic                    i_clk = 0;
    logic                    i_rst_n = 0;
    logic                    start = 0;
    logic                    busy;
    logic                    i_cfg_we = 0;
    logic [CFG_W-1:0]        i_cfg_wdata = '0;
    logic                    i_mode = 0;
    logic signed [SAMPLE_BITS-1:0] i_sample = '0;
    logic                    i_last = 0;
    logic                    o_strobe;
    logic                    o_status;
    logic [LA_W-1:0]         o_best_lag;
    logic [QW-1:0]           o_best_corr;

    lag_scoreboard sb = new();
    int  n_items = 0;
    bit  idle_en = 1;

    best_lag_correlation_search_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_mode      (i_mode),
        .i_sample    (i_sample),
        .i_last      (i_last),
        .o_strobe    (o_strobe),
        .o_status    (o_status),
        .o_best_lag  (o_best_lag),
        .o_best_corr (o_best_corr)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result(o_status, o_best_lag, o_best_corr);
    end

    // called in a posedge time step; returns in the step the request is taken
    task automatic send_req(bit mode, bit [15:0] sample, bit last);
        if (idle_en && $urandom_range(99) < 26) begin
            start <= 0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        start    <= 1;
        i_mode   <= mode;
        i_sample <= sample;
        i_last   <= last;
        do @(posedge i_clk); while (busy);
        sb.note_request(mode, sample, last);
        n_items++;
    endtask

    task automatic write_max_shift(int unsigned v);
        start <= 0;
        @(posedge i_clk);
        while (sb.pending() > 0 || busy) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_we    <= 1;
        i_cfg_wdata <= v[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 0;
        // the register keeps only its low bits
        sb.max_shift = v[CFG_W-1:0];
    endtask

    // one series pair: short then long, last on the final long sample
    // kind 0: random full range, 1: short copied from long plus noise
    task automatic run_set(int n, int m, int kind);
        bit [15:0] ys[$];
        int sh, v;
        ys = {};
        for (int i = 0; i < m; i++)
            ys.push_back(kind ? 16'($signed($urandom_range(0, 32000)) - 16000)
                              : 16'($urandom));
        sh = (m > n) ? $urandom_range(0, m - n - 1) : 0;
        for (int i = 0; i < n; i++) begin
            if (kind && sh + i < m) begin
                v = $signed(ys[sh + i]) + $signed($urandom_range(0, 200)) - 100;
                send_req(0, 16'(v), $urandom_range(9) == 0);
            end else begin
                send_req(0, 16'($urandom), $urandom_range(9) == 0);
            end
        end
        for (int i = 0; i < m; i++)
            send_req(1, ys[i], i == m - 1);
    endtask

    initial begin
        int n, m, sel;
        int unsigned shifts[7] = '{0, 1, 2, 3, 17, 512, 1023};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // empty series, then long not longer than short
        send_req(1, 16'h0000, 1);
        send_req(0, 16'h1234, 0);
        send_req(0, 16'h4321, 0);
        send_req(0, 16'h0001, 0);
        send_req(1, 16'h7fff, 0);
        send_req(1, 16'h8000, 1);
        // extremes; last on a short request is ignored
        send_req(0, 16'h8000, 1);
        send_req(0, 16'h7fff, 1);
        send_req(0, 16'h0000, 0);
        send_req(1, 16'h7fff, 0);
        send_req(1, 16'h8000, 0);
        send_req(1, 16'h7fff, 0);
        send_req(1, 16'h0000, 0);
        send_req(1, 16'hffff, 1);
        // constant short series: zero denominator
        send_req(0, 16'h0005, 0);
        send_req(0, 16'h0005, 0);
        send_req(1, 16'h0100, 0);
        send_req(1, 16'h0200, 0);
        send_req(1, 16'h0300, 1);
        // anti-correlated only: no winning lag
        send_req(0, 16'h0010, 0);
        send_req(0, 16'h0020, 0);
        send_req(1, 16'h0020, 0);
        send_req(1, 16'h0010, 0);
        send_req(1, 16'h0000, 1);

        write_max_shift(0);
        run_set(3, 8, 1);
        write_max_shift(1);
        run_set(3, 8, 1);
        write_max_shift(1023);
        run_set(4, 12, 1);
        // full stores with overflow drops on both sides
        write_max_shift(512);
        run_set(SHORT_DEPTH + 4, LONG_DEPTH + 6, 1);

        while (n_items < 1300) begin
            idle_en = !(n_items > 500 && n_items < 800);
            if ($urandom_range(9) == 0)
                write_max_shift(shifts[$urandom_range(0, 6)] +
                                ($urandom_range(3) == 0 ? $urandom_range(0, 40) : 0));
            sel = $urandom_range(99);
            n = $urandom_range(1, 8);
            if (sel < 8) begin
                run_set($urandom_range(0, 1) ? 0 : n, $urandom_range(1, n), 0);
            end else begin
                m = n + $urandom_range(1, 24);
                run_set(n, m, sel < 50);
            end
        end

        start <= 0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0)
            $display("best_lag_correlation_search_unit regression: pass");
        else
            $display("best_lag_correlation_search_unit regression: fail");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("best_lag_correlation_search_unit regression: fail");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+hdl
hdl/blc_pkg.sv
hdl/blc_cell.sv
hdl/blc_corr.sv
hdl/best_lag_correlation_search_unit.sv
tb/sv/tb_top.sv
